// ===== rtl/core/boot_region_allocator_core_macros.svh =====
// Assertion macros for the boot region allocator
`ifndef BOOT_REGION_ALLOCATOR_CORE_MACROS_SVH
`define BOOT_REGION_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define BRA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BRA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bra_pkg.sv =====
// Shared constants and types of the boot region allocator
package bra_pkg;
	localparam int ADDR_W          = 52;
	localparam int PAGES_W         = 20;
	localparam int SLOTS_DEF       = 16;
	localparam int PAGE_BYTES_DEF  = 4096;
	localparam logic [ADDR_W-1:0] LOW_LIMIT = 52'h0_0001_0000_0000;

	localparam logic [1:0] MODE_ADD_USABLE = 2'd0;
	localparam logic [1:0] MODE_ADD_RESVD  = 2'd1;
	localparam logic [1:0] MODE_ALLOC      = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_ZERO      = 3'd2;
	localparam logic [2:0] ST_NOFIT     = 3'd3;
	localparam logic [2:0] ST_RES_FULL  = 3'd4;

	// append write into one cell
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] size;
	} bra_wr_t;

	// scan token state leaving a cell
	typedef struct packed {
		logic tok;
		logic hit;
	} bra_scan_t;
endpackage

// ===== rtl/core/bra_ucell.sv =====
// One usable-region cell: holds an entry and tests it when the scan token arrives
module bra_ucell import bra_pkg::*; #(
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bra_wr_t           wr,
	input  logic              tok_in,
	input  logic [ADDR_W-1:0] span,
	input  logic [ADDR_W-1:0] kend,
	output bra_scan_t         scan,
	output logic [ADDR_W-1:0] base
);
	localparam logic [ADDR_W-1:0] PageLim = ADDR_W'(PAGE_BYTES);

	logic              tok_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] size_q;
	logic              qual;

	// first-fit qualification of this entry
	assign qual = (size_q > PageLim) && (base_q < LOW_LIMIT) && (base_q > kend)
		&& (size_q >= span);
	assign scan.hit = tok_q & qual;
	assign scan.tok = tok_q & ~qual;
	assign base     = scan.hit ? base_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	// append or carve from the base
	always_ff @(posedge clk) begin
		if (wr.en) begin
			base_q <= wr.base;
			size_q <= wr.size;
		end else if (scan.hit) begin
			base_q <= base_q + span;
			size_q <= size_q - span;
		end
	end
endmodule

// ===== rtl/core/bra_rcell.sv =====
// One reserved-region cell: merges the carved span when adjacent
module bra_rcell import bra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bra_wr_t           wr,
	input  logic              tok_in,
	input  logic [ADDR_W-1:0] start,
	input  logic [ADDR_W-1:0] span,
	output bra_scan_t         scan
);
	logic              tok_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] size_q;
	logic [ADDR_W:0]   span_end;
	logic [ADDR_W:0]   ent_end;
	logic              below;
	logic              above;

	// adjacency, no wrap on either end
	assign span_end = {1'b0, start} + {1'b0, span};
	assign ent_end  = {1'b0, base_q} + {1'b0, size_q};
	assign below    = span_end == {1'b0, base_q};
	assign above    = ent_end == {1'b0, start};
	assign scan.hit = tok_q & (below | above);
	assign scan.tok = tok_q & ~(below | above);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	// append, or grow downward / upward
	always_ff @(posedge clk) begin
		if (wr.en) begin
			base_q <= wr.base;
			size_q <= wr.size;
		end else if (scan.hit) begin
			if (below) begin
				base_q <= start;
			end
			size_q <= size_q + span;
		end
	end
endmodule

// ===== rtl/core/boot_region_allocator_core.sv =====
// Top level of the boot region allocator: control, two rows of cells, APB register
//
// An item is taken when start is high and busy is low; its one result word appears
// on alloc_addr/status for a single cycle with done high and cannot be held off.
// Adds answer in the cycle after acceptance and leave busy low. An allocation walks a
// token along the usable row, one cell per cycle, then along the reserved row, one
// cell per cycle; a full reserved row answers without a scan. busy stays high until
// the cycle its result is shown. kernel_end_addr sits at byte address 0 of the 64-bit
// APB port.
`include "boot_region_allocator_core_macros.svh"
module boot_region_allocator_core import bra_pkg::*; #(
	parameter int REGION_SLOTS = SLOTS_DEF,
	parameter int PAGE_BYTES   = PAGE_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [ADDR_W-1:0]  region_base,
	input  logic [ADDR_W-1:0]  region_length,
	input  logic [PAGES_W-1:0] page_count,
	output logic               done,
	output logic [ADDR_W-1:0]  alloc_addr,
	output logic [2:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);
	localparam int CW = $clog2(REGION_SLOTS + 1);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_USCAN = 2'd1;
	localparam logic [1:0] S_RSCAN = 2'd2;

	logic [1:0]        state_q;
	logic [CW-1:0]     ucount_q;
	logic [CW-1:0]     rcount_q;
	logic [ADDR_W-1:0] kend_q;
	logic [ADDR_W-1:0] span_q;
	logic [ADDR_W-1:0] addr_q;
	logic              done_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [2:0]        res_status_q;

	logic              accept;
	logic              uinject;
	logic              rinject;
	logic              uany_hit;
	logic              uany_tok;
	logic              rany_hit;
	logic              rany_tok;
	logic [ADDR_W-1:0] uhit_base;
	logic              rappend;
	logic [ADDR_W-1:0] rappend_base;
	logic              utok_in [REGION_SLOTS];
	logic              rtok_in [REGION_SLOTS];
	bra_scan_t         uscan [REGION_SLOTS];
	bra_scan_t         rscan [REGION_SLOTS];
	logic [ADDR_W-1:0] ubase [REGION_SLOTS];
	bra_wr_t           uwr [REGION_SLOTS];
	bra_wr_t           rwr [REGION_SLOTS];

	assign accept = start && !busy;
	assign busy   = state_q != S_IDLE;
	assign pready = 1'b1;
	assign prdata = paddr[3] ? 64'd0 : {{(64-ADDR_W){1'b0}}, kend_q};
	assign done       = done_q;
	assign alloc_addr = res_addr_q;
	assign status     = res_status_q;

	// token launch points
	assign uinject = accept && mode == MODE_ALLOC && page_count != '0
		&& rcount_q < CW'(REGION_SLOTS) && ucount_q != '0;
	assign rinject = state_q == S_USCAN && uany_hit && rcount_q != '0;

	// gather row status
	always_comb begin
		uany_hit  = 1'b0;
		uany_tok  = 1'b0;
		rany_hit  = 1'b0;
		rany_tok  = 1'b0;
		uhit_base = '0;
		for (int i = 0; i < REGION_SLOTS; i++) begin
			uany_hit  = uany_hit | uscan[i].hit;
			uany_tok  = uany_tok | uscan[i].tok;
			rany_hit  = rany_hit | rscan[i].hit;
			rany_tok  = rany_tok | rscan[i].tok;
			uhit_base = uhit_base | ubase[i];
		end
	end

	// new reserved entry: straight after the usable hit when the reserved row is empty, or after a missed merge
	always_comb begin
		rappend      = 1'b0;
		rappend_base = addr_q;
		if (state_q == S_USCAN && uany_hit && rcount_q == '0) begin
			rappend      = 1'b1;
			rappend_base = uhit_base;
		end else if (state_q == S_RSCAN && !rany_hit && !rany_tok) begin
			rappend = 1'b1;
		end
	end

	// cell rows
	for (genvar i = 0; i < REGION_SLOTS; i++) begin : g_row
		if (i == 0) begin : g_head
			assign utok_in[i] = uinject;
			assign rtok_in[i] = rinject;
		end else begin : g_link
			assign utok_in[i] = uscan[i-1].tok && ucount_q > CW'(i);
			assign rtok_in[i] = rscan[i-1].tok && rcount_q > CW'(i);
		end
		assign uwr[i].en   = accept && mode == MODE_ADD_USABLE && ucount_q == CW'(i);
		assign uwr[i].base = region_base;
		assign uwr[i].size = region_length;
		assign rwr[i].en   = ((accept && mode == MODE_ADD_RESVD) || rappend)
			&& rcount_q == CW'(i);
		assign rwr[i].base = rappend ? rappend_base : region_base;
		assign rwr[i].size = rappend ? span_q : region_length;

		bra_ucell #(.PAGE_BYTES(PAGE_BYTES)) u_ucell (
			.clk(clk), .arst_n(arst_n), .wr(uwr[i]), .tok_in(utok_in[i]),
			.span(span_q), .kend(kend_q), .scan(uscan[i]), .base(ubase[i])
		);
		bra_rcell u_rcell (
			.clk(clk), .arst_n(arst_n), .wr(rwr[i]), .tok_in(rtok_in[i]),
			.start(addr_q), .span(span_q), .scan(rscan[i])
		);
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kend_q <= '0;
		end else if (psel && penable && pwrite && pready && !paddr[3]) begin
			kend_q <= pwdata[ADDR_W-1:0];
		end
	end

	// span and hit address
	always_ff @(posedge clk) begin
		if (accept) begin
			span_q <= ADDR_W'(page_count) * ADDR_W'(PAGE_BYTES);
		end
		if (state_q == S_USCAN && uany_hit) begin
			addr_q <= uhit_base;
		end
	end

	always_ff @(posedge clk) begin
		res_addr_q   <= '0;
		res_status_q <= ST_OK;
		if (accept) begin
			if (mode == MODE_ADD_USABLE) begin
				res_status_q <= (ucount_q >= CW'(REGION_SLOTS)) ? ST_FULL : ST_OK;
			end else if (mode == MODE_ADD_RESVD) begin
				res_status_q <= (rcount_q >= CW'(REGION_SLOTS)) ? ST_FULL : ST_OK;
			end else if (mode == MODE_ALLOC) begin
				if (page_count == '0) begin
					res_status_q <= ST_ZERO;
				end else if (rcount_q >= CW'(REGION_SLOTS)) begin
					res_status_q <= ST_RES_FULL;
				end else if (ucount_q == '0) begin
					res_status_q <= ST_NOFIT;
				end
			end
		end else if (state_q == S_USCAN) begin
			if (uany_hit) begin
				res_addr_q <= uhit_base;
			end else begin
				res_status_q <= ST_NOFIT;
			end
		end else if (state_q == S_RSCAN) begin
			res_addr_q <= addr_q;
		end
	end

	// control: state, counts, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ucount_q <= '0;
			rcount_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (uwr[0].en || (accept && mode == MODE_ADD_USABLE
					&& ucount_q < CW'(REGION_SLOTS))) begin
				ucount_q <= ucount_q + 1'b1;
			end
			if (((accept && mode == MODE_ADD_RESVD) || rappend)
					&& rcount_q < CW'(REGION_SLOTS)) begin
				rcount_q <= rcount_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (uinject) begin
						state_q <= S_USCAN;
					end else if (accept) begin
						done_q <= 1'b1;
					end
				end
				S_USCAN: begin
					if (rinject) begin
						state_q <= S_RSCAN;
					end else if (uany_hit || !uany_tok) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_RSCAN: begin
					if (rany_hit || !rany_tok) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BRA_ASSERT_NXT(a_accept_answers, accept, busy || done, "accepted word neither busy nor done")
	`BRA_ASSERT_NOW(a_counts_bound, 1'b1, ucount_q <= CW'(REGION_SLOTS) && rcount_q <= CW'(REGION_SLOTS), "count past slots")
	`BRA_ASSERT_NOW(a_one_hit, 1'b1, $onehot0({uany_hit, rany_hit}), "hits in both rows at once")
	`BRA_ASSERT_NOW(a_done_status, done, status <= ST_RES_FULL, "bad status code")
	`BRA_ASSERT_NOW(a_idle_no_token, state_q == S_IDLE, !uany_tok && !rany_tok, "token live while idle")
endmodule

// ===== tb/testbench.sv =====
// Testbench for boot_region_allocator_core: directed and random words against a predictor
`timescale 1ns / 1ps
module testbench;
	import bra_pkg::*;

	localparam int SLOTS = SLOTS_DEF;
	localparam int PAGE  = PAGE_BYTES_DEF;
	localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [2:0]        st;
	} answer_t;

	// table model plus queue of answers still owed by the block
	class region_scoreboard;
		logic [ADDR_W-1:0] usable_b[SLOTS], usable_s[SLOTS];
		logic [ADDR_W-1:0] resvd_b[SLOTS], resvd_s[SLOTS];
		int usable_n, resvd_n;
		logic [ADDR_W-1:0] kernel_end;
		answer_t owed[$];
		int errors;
		int tally[8];
		int answers;

		function new();
			usable_n = 0;
			resvd_n = 0;
			kernel_end = '0;
			errors = 0;
			answers = 0;
			foreach (tally[k]) tally[k] = 0;
		endfunction

		// merge a carved span into an adjacent reserved entry, else append it
		function void reserve_span(logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] span);
			for (int j = 0; j < resvd_n; j++) begin
				if ({1'b0, b} + {1'b0, span} == {1'b0, resvd_b[j]}) begin
					resvd_b[j] = b;
					resvd_s[j] = resvd_s[j] + span;
					return;
				end
				if ({1'b0, resvd_b[j]} + {1'b0, resvd_s[j]} == {1'b0, b}) begin
					resvd_s[j] = resvd_s[j] + span;
					return;
				end
			end
			if (resvd_n < SLOTS) begin
				resvd_b[resvd_n] = b;
				resvd_s[resvd_n] = span;
				resvd_n++;
			end
		endfunction

		// first-fit carve from the usable table
		function answer_t allocate(logic [PAGES_W-1:0] pages);
			logic [ADDR_W-1:0] span, b, s;
			answer_t a;
			a.addr = '0;
			if (pages == 0) begin
				a.st = ST_ZERO;
				return a;
			end
			if (resvd_n >= SLOTS) begin
				a.st = ST_RES_FULL;
				return a;
			end
			span = ADDR_W'(pages) * ADDR_W'(PAGE);
			for (int i = 0; i < usable_n; i++) begin
				b = usable_b[i];
				s = usable_s[i];
				if (s <= ADDR_W'(PAGE) || b >= LOW_LIMIT || b <= kernel_end || s < span)
					continue;
				usable_b[i] = b + span;
				usable_s[i] = s - span;
				reserve_span(b, span);
				a.addr = b;
				a.st = ST_OK;
				return a;
			end
			a.st = ST_NOFIT;
			return a;
		endfunction

		// accepted input word: predict its answer
		function void note_word(logic [1:0] m, logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] len,
				logic [PAGES_W-1:0] pages);
			answer_t a;
			a.addr = '0;
			a.st = ST_OK;
			if (m == MODE_ADD_USABLE) begin
				if (usable_n >= SLOTS) a.st = ST_FULL;
				else begin
					usable_b[usable_n] = b;
					usable_s[usable_n] = len;
					usable_n++;
				end
			end else if (m == MODE_ADD_RESVD) begin
				if (resvd_n >= SLOTS) a.st = ST_FULL;
				else begin
					resvd_b[resvd_n] = b;
					resvd_s[resvd_n] = len;
					resvd_n++;
				end
			end else if (m == MODE_ALLOC) begin
				a = allocate(pages);
			end
			owed.push_back(a);
		endfunction

		// result word from the block against the oldest prediction
		function void check_word(logic [ADDR_W-1:0] addr, logic [2:0] st);
			answer_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result addr=%h status=%0d", $time, addr, st);
				errors++;
				return;
			end
			e = owed.pop_front();
			answers++;
			tally[e.st]++;
			if (addr !== e.addr) begin
				$display("%0t: alloc_addr expected %h actual %h", $time, e.addr, addr);
				errors++;
			end
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] mode = '0;
	logic [ADDR_W-1:0] region_base = '0;
	logic [ADDR_W-1:0] region_length = '0;
	logic [PAGES_W-1:0] page_count = '0;
	logic done;
	logic [ADDR_W-1:0] alloc_addr;
	logic [2:0] status;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	region_scoreboard sb = new();
	int burst_left = 0;
	int phase_allocs;

	boot_region_allocator_core dut (.*);

	always #4 clk = ~clk;

	// results are stable between edges; sample mid-cycle
	always @(negedge clk)
		if (arst_n && done) sb.check_word(alloc_addr, status);

	function automatic logic [ADDR_W-1:0] rand_addr();
		return ADDR_W'({$urandom, $urandom});
	endfunction

	// present one word, hold it until taken, then idle between bursts
	task automatic send_word(logic [1:0] m, logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] len,
			logic [PAGES_W-1:0] pages);
		int gap;
		start <= 1'b1;
		mode <= m;
		region_base <= b;
		region_length <= len;
		page_count <= pages;
		do @(negedge clk); while (busy);
		@(posedge clk);
		sb.note_word(m, b, len, pages);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 3);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// wait for every owed answer, then let a trailing scan drain
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0 || busy) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_kernel_end(logic [ADDR_W-1:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= '0;
		pwdata <= 64'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.kernel_end = v;
		@(posedge clk);
	endtask

	// allocation with mostly small page counts, some large ones
	task automatic random_alloc();
		logic [PAGES_W-1:0] pages;
		case ($urandom_range(0, 9))
			0: pages = PAGES_W'($urandom_range(1, 20'hFFFFF));
			1, 2: pages = PAGES_W'($urandom_range(1, 4096));
			default: pages = PAGES_W'($urandom_range(1, 16));
		endcase
		send_word(MODE_ALLOC, rand_addr(), rand_addr(), pages);
	endtask

	// one phase: set kernel end, add a few regions, then mostly allocations
	task automatic run_phase(logic [ADDR_W-1:0] kend, int n_usable, int n_items);
		logic [ADDR_W-1:0] b, s;
		drain();
		write_kernel_end(kend);
		for (int i = 0; i < n_usable; i++) begin
			b = ADDR_W'({$urandom_range(1, 32'hFFFF0), 12'h0});
			case ($urandom_range(0, 7))
				0: s = ADDR_W'(PAGE);
				1: s = ADDR_W'(PAGE + 1);
				default: s = ADDR_W'({$urandom_range(2, 16'h4000), 12'h0});
			endcase
			send_word(MODE_ADD_USABLE, b, s, PAGES_W'($urandom));
		end
		if ($urandom_range(0, 1))
			send_word(MODE_ADD_RESVD, ADDR_W'({$urandom_range(1, 32'hFFFFF), 12'h0}),
				ADDR_W'({$urandom_range(1, 64), 12'h0}), PAGES_W'($urandom));
		for (int i = 0; i < n_items; i++) begin
			case ($urandom_range(0, 19))
				0: send_word(2'd3, rand_addr(), rand_addr(), PAGES_W'($urandom));
				1: send_word(MODE_ALLOC, rand_addr(), rand_addr(), '0);
				default: begin
					random_alloc();
					phase_allocs++;
				end
			endcase
		end
	endtask

	initial begin
		phase_allocs = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_kernel_end('0);

		// directed: unused mode, zero request, empty table, field extremes
		send_word(2'd3, ADDR_ONES, ADDR_ONES, '1);
		send_word(2'd3, '0, '0, '0);
		send_word(MODE_ALLOC, '0, '0, '0);
		send_word(MODE_ALLOC, ADDR_ONES, ADDR_ONES, 20'd1);
		send_word(MODE_ADD_USABLE, ADDR_ONES, ADDR_ONES, '1);
		send_word(MODE_ADD_USABLE, 52'h1000, 52'h2000, '1);
		send_word(MODE_ALLOC, '0, '0, '1);
		send_word(MODE_ALLOC, '0, '0, 20'd1);
		send_word(MODE_ALLOC, '0, '0, 20'd1);
		send_word(MODE_ADD_RESVD, ADDR_ONES, ADDR_ONES, '0);
		send_word(MODE_ADD_USABLE, 52'h10_0000, 52'h1000, '0);
		send_word(MODE_ADD_USABLE, 52'h20_0000, 52'h1001, '0);
		send_word(MODE_ADD_USABLE, 52'hFFFF_F000, 52'h10_0000, '0);
		send_word(MODE_ALLOC, '0, '0, 20'd2);
		drain();
		write_kernel_end(52'h0FFF_FFFF);
		send_word(MODE_ALLOC, '0, '0, 20'd1);

		// random phases over several kernel end settings
		run_phase(ADDR_W'($urandom_range(0, 32'h3FFF_FFFF)), 3, 340);
		run_phase('0, 3, 340);
		run_phase(ADDR_ONES, 0, 200);
		run_phase(ADDR_W'($urandom), 2, 340);

		// fill both tables to see the full-table answers
		drain();
		write_kernel_end('0);
		for (int i = 0; i < SLOTS + 2; i++)
			send_word(MODE_ADD_USABLE, ADDR_W'({$urandom_range(1, 32'hFFFFF), 12'h0}),
				52'h10_0000, '0);
		for (int i = 0; i < SLOTS + 2; i++)
			send_word(MODE_ADD_RESVD, rand_addr(), rand_addr(), '0);
		for (int i = 0; i < 6; i++) random_alloc();

		drain();
		$display("Covered %0d answers over %0d random allocations and 7 kernel end writes",
			sb.answers, phase_allocs);
		$display("ok %0d, full %0d, zero %0d, no fit %0d, reserved full %0d",
			sb.tally[ST_OK], sb.tally[ST_FULL], sb.tally[ST_ZERO], sb.tally[ST_NOFIT],
			sb.tally[ST_RES_FULL]);
		if (sb.errors == 0)
			$display("PASS boot_region_allocator_core");
		else
			$display("FAIL boot_region_allocator_core");
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("FAIL boot_region_allocator_core");
		$finish;
	end
endmodule
